FILE: src/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the running median filter
// Beat payloads of both channels, the sample and median types and the
// control bundle that the top level broadcasts to every sorting cell.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MEDIAN_BITS = SAMPLE_BITS + 1;
  localparam int WIN_BITS    = 6;

  localparam logic [WIN_BITS-1:0] WIN_RESET = 6'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MEDIAN_BITS-1:0] median_t;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } rmf_in_t;

  typedef struct packed {
    median_t median_x2;
    logic    last_out;
  } rmf_out_t;

  // Broadcast to the whole cell chain in every cycle.
  typedef struct packed {
    logic    ins;
    logic    drop;
    sample_t ins_val;
    sample_t drop_val;
  } cell_ctrl_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } rmf_state_e;

endpackage

FILE: src/rmf_cell.sv
// ----------------------------------------------------------------------------
// rmf_cell: one slot of the sorted sample chain
// Holds one sample and its age. Each cycle it may close the gap left by the
// oldest sample and take part in a sorted insertion, looking only at its two
// neighbours and the broadcast control bundle.
// ----------------------------------------------------------------------------
module rmf_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 6
) (
  input  logic                clk_i,
  input  rmf_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       held_i,
  input  logic [CW-1:0]       kept_cnt_i,
  input  logic [CW-1:0]       oldest_age_i,
  input  rmf_pkg::sample_t    up_val_i,
  input  logic [CW-1:0]       up_age_i,
  input  rmf_pkg::sample_t    lo_val_i,
  input  logic [CW-1:0]       lo_age_i,
  input  logic                lo_lt_i,
  output rmf_pkg::sample_t    val_o,
  output logic [CW-1:0]       age_o,
  output rmf_pkg::sample_t    kept_val_o,
  output logic [CW-1:0]       kept_age_o,
  output logic                kept_lt_o,
  output rmf_pkg::sample_t    tap_o
);
  import rmf_pkg::*;

  sample_t       val_q, val_d;
  logic [CW-1:0] age_q, age_d;
  logic          own_v, kept_v, is_oldest, gone;

  assign own_v     = int'(held_i) > INDEX;
  assign kept_v    = int'(kept_cnt_i) > INDEX;
  assign is_oldest = own_v && (age_q == oldest_age_i);

  // The oldest sample is the last of any run of equal values, so every slot
  // at or above it holds either that sample or a strictly larger one.
  assign gone = ctrl_i.drop && own_v && ((val_q > ctrl_i.drop_val) || is_oldest);

  assign tap_o      = (ctrl_i.drop && is_oldest) ? val_q : '0;
  assign kept_val_o = gone ? up_val_i : val_q;
  assign kept_age_o = gone ? up_age_i : age_q;
  assign kept_lt_o  = kept_v && (kept_val_o < ctrl_i.ins_val);
  assign val_o      = val_q;
  assign age_o      = age_q;

  always_comb begin
    val_d = val_q;
    age_d = age_q;
    if (ctrl_i.ins) begin
      if (kept_lt_o) begin
        val_d = kept_val_o;
        age_d = kept_age_o + CW'(1);
      end else if (lo_lt_i) begin
        val_d = ctrl_i.ins_val;
        age_d = '0;
      end else begin
        val_d = lo_val_i;
        age_d = lo_age_i + CW'(1);
      end
    end else if (ctrl_i.drop) begin
      val_d = kept_val_o;
      age_d = kept_age_o;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

endmodule

FILE: src/rmf_median.sv
// ----------------------------------------------------------------------------
// rmf_median: middle-value pick from the sorted chain
// Selects the lower and upper middle slots for the held count and adds
// them, which gives twice the median for odd and even counts alike.
// ----------------------------------------------------------------------------
module rmf_median #(
  parameter int NC = 63,
  parameter int CW = 6
) (
  input  rmf_pkg::sample_t val_i [NC],
  input  logic [CW-1:0]    held_i,
  output rmf_pkg::median_t median_o
);
  import rmf_pkg::*;

  logic [CW-1:0] lo_idx, hi_idx;
  sample_t       lo_val, hi_val;

  assign lo_idx = (held_i - CW'(1)) >> 1;
  assign hi_idx = held_i >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < NC; i++) begin
      if (int'(lo_idx) == i) lo_val = lo_val | val_i[i];
      if (int'(hi_idx) == i) hi_val = hi_val | val_i[i];
    end
  end

  assign median_o = median_t'({lo_val[SAMPLE_BITS-1], lo_val})
                  + median_t'({hi_val[SAMPLE_BITS-1], hi_val});

endmodule

FILE: src/running_median_filter_top.sv
// ----------------------------------------------------------------------------
// running_median_filter_top: sliding-window running median over a sample set
// Samples are kept in a chain of sorting cells; each result is twice the
// median of the current window, and the last sample of a set flushes the
// remaining results with a shrinking window.
//
//   channel | direction | beat payload              | handshake
//   in      | input     | sample, last_sample       | in_valid_i / in_ready_o
//   out     | output    | median_x2, last_out       | out_valid_o / out_ready_i
//   cfg     | input     | window size (6 bits)      | cfg_valid_i / cfg_ready_o
//
// One sample is taken per cycle while in_ready_o is high; the accepted beat
// updates the chain and pend_q, and its result is then loaded into the output
// register. The cell chain removes at most one sample per cycle, so after the
// window has been made smaller the next sample waits until the surplus held
// samples are gone. The flush after the last sample gives one result per
// cycle while the output is free, pausing for each sample dropped while the
// window shrinks. Reset is immediate: no clearing pass. A stalled output
// holds the chain as soon as a further result would need the output register.
module running_median_filter_top #(
  parameter int MAX_WINDOW = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rmf_pkg::rmf_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rmf_pkg::rmf_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rmf_pkg::WIN_BITS-1:0]   cfg_data_i
);
  import rmf_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int NC = MAX_WINDOW;

  logic [WIN_BITS-1:0] win_q;
  rmf_state_e          st_q, st_d;
  logic [CW-1:0]       held_q, held_d;
  logic [CW-1:0]       recv_q, recv_d;
  logic [CW-1:0]       m_q, m_d;
  logic                pend_q, pend_d;
  logic                out_valid_q;
  rmf_out_t            out_q;

  logic [CW-1:0] w_eff, left, right, recv_inc;
  logic [CW-1:0] oldest_age, kept_cnt;
  logic [CW:0]   flush_lim;
  logic          out_free, emit_blk, drop, ins, load, load_last;
  sample_t       drop_val;
  median_t       median;
  cell_ctrl_t    ctrl;

  sample_t       cval     [NC];
  sample_t       cval_ext [NC+1];
  logic [CW-1:0] cage_ext [NC+1];
  sample_t       kval_ext [NC+1];
  logic [CW-1:0] kage_ext [NC+1];
  logic          klt_ext  [NC+1];
  sample_t       tap      [NC];

  // Window size as the filter uses it: zero acts as one, oversize as maximum.
  always_comb begin
    if (win_q == '0) begin
      w_eff = CW'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(win_q);
    end
  end

  assign left      = w_eff >> 1;
  assign right     = w_eff - left;
  assign recv_inc  = (recv_q < right) ? recv_q + CW'(1) : right;
  assign flush_lim = {1'b0, left} + {1'b0, m_q};
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    st_d       = st_q;
    held_d     = held_q;
    recv_d     = recv_q;
    m_d        = m_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    emit_blk   = 1'b0;
    drop       = 1'b0;
    ins        = 1'b0;
    load       = 1'b0;
    load_last  = 1'b0;
    case (st_q)
      ST_RUN: begin
        // A pending result must reach the output register before the chain moves.
        emit_blk   = pend_q && !out_free;
        in_ready_o = !emit_blk && !(held_q > w_eff);
        load       = pend_q && out_free;
        pend_d     = pend_q && !out_free;
        if (in_valid_i && !emit_blk && (held_q > w_eff)) begin
          drop   = 1'b1;
          held_d = held_q - CW'(1);
        end else if (in_valid_i && in_ready_o) begin
          ins    = 1'b1;
          drop   = (held_q == w_eff);
          held_d = held_q - CW'(drop) + CW'(1);
          recv_d = recv_inc;
          if (in_data_i.last_sample) begin
            st_d = ST_FLUSH;
            m_d  = recv_inc;
          end else begin
            pend_d = (recv_inc == right);
          end
        end
      end
      ST_FLUSH: begin
        if ({1'b0, held_q} > flush_lim) begin
          drop   = 1'b1;
          held_d = held_q - CW'(1);
        end else if (out_free) begin
          load      = 1'b1;
          load_last = (m_q == CW'(1));
          m_d       = m_q - CW'(1);
          if (m_q == CW'(1)) begin
            held_d = '0;
            recv_d = '0;
            st_d   = ST_RUN;
          end
        end
      end
      default: begin
        st_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      held_q      <= '0;
      recv_q      <= '0;
      m_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= WIN_RESET;
    end else begin
      st_q   <= st_d;
      held_q <= held_d;
      recv_q <= recv_d;
      m_q    <= m_d;
      pend_q <= pend_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.median_x2 <= median;
      out_q.last_out  <= load_last;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Value of the oldest held sample, picked from the one cell that owns it.
  always_comb begin
    drop_val = '0;
    for (int i = 0; i < NC; i++) begin
      drop_val = drop_val | tap[i];
    end
  end

  assign oldest_age    = held_q - CW'(1);
  assign kept_cnt      = held_q - CW'(drop);
  assign ctrl.ins      = ins;
  assign ctrl.drop     = drop;
  assign ctrl.ins_val  = in_data_i.sample;
  assign ctrl.drop_val = drop_val;

  assign kval_ext[0] = '0;
  assign kage_ext[0] = '0;
  assign klt_ext[0]  = 1'b1;
  assign cval_ext[NC] = '0;
  assign cage_ext[NC] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rmf_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .held_i       (held_q),
      .kept_cnt_i   (kept_cnt),
      .oldest_age_i (oldest_age),
      .up_val_i     (cval_ext[i+1]),
      .up_age_i     (cage_ext[i+1]),
      .lo_val_i     (kval_ext[i]),
      .lo_age_i     (kage_ext[i]),
      .lo_lt_i      (klt_ext[i]),
      .val_o        (cval[i]),
      .age_o        (cage_ext[i]),
      .kept_val_o   (kval_ext[i+1]),
      .kept_age_o   (kage_ext[i+1]),
      .kept_lt_o    (klt_ext[i+1]),
      .tap_o        (tap[i])
    );
    assign cval_ext[i] = cval[i];
  end

  rmf_median #(
    .NC (NC),
    .CW (CW)
  ) u_median (
    .val_i    (cval),
    .held_i   (held_q),
    .median_o (median)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(held_q) <= MAX_WINDOW)
    else $error("held sample count exceeds the chain length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FLUSH) |-> (m_q != '0))
    else $error("flush running with no result left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (st_q == ST_RUN))
    else $error("pending result while flushing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |-> (held_q != '0))
    else $error("sample removal from an empty chain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && load_last) |=> ((held_q == '0) && (st_q == ST_RUN) && out_valid_q))
    else $error("block not cleared after the final result of a set");
`endif

endmodule

FILE: tb/sv/running_median_filter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_filter_top_tb: self-checking bench for the running median
// Drives sample beats and window size writes into the filter and predicts
// every filtered value with an independent sorted-window model. Both sides
// stall at random. The run starts with a short table of edge cases and then
// covers many window sizes, short sets and a resize inside a set.
// ----------------------------------------------------------------------------
module running_median_filter_top_tb;
  import rmf_pkg::*;

  localparam int MAX_WIN = 63;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smp;
    logic                   lst;
    logic                   fixed_exp;
    logic [MEDIAN_BITS-1:0] exp_med;
    logic                   exp_last;
  } stim_row_t;

  // Single-sample sets have an obvious result; all other rows go through the model.
  localparam stim_row_t STIM_ROWS [20] = '{
    '{16'h7FFF, 1'b1, 1'b1, 17'h0FFFE, 1'b1},
    '{16'h8000, 1'b1, 1'b1, 17'h10000, 1'b1},
    '{16'h0000, 1'b1, 1'b1, 17'h00000, 1'b1},
    '{16'hFFFF, 1'b1, 1'b1, 17'h1FFFE, 1'b1},
    '{16'h0064, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'hFFFB, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h7FFF, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h8000, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'hAAAA, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'hFFFF, 1'b1, 1'b0, 17'h00000, 1'b0},
    '{16'h000A, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0014, 1'b1, 1'b0, 17'h00000, 1'b0},
    '{16'h0005, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0005, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0005, 1'b0, 1'b0, 17'h00000, 1'b0},
    '{16'h0005, 1'b1, 1'b0, 17'h00000, 1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  rmf_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  rmf_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [WIN_BITS-1:0] cfg_data_i;

  // Model of the filter: held samples sorted and in arrival order.
  int                  win_sorted [MAX_WIN];
  int                  win_ring [MAX_WIN];
  int                  win_wr_ptr;
  int                  win_held;
  int                  win_seen;
  logic [WIN_BITS-1:0] win_size;

  rmf_out_t median_q [$];
  int       mismatch_count;
  int       samples_sent;
  int       sets_sent;
  int       results_seen;
  bit       tx_burst;
  bit       rx_burst;
  bit       hold_req;

  running_median_filter_top #(
    .MAX_WINDOW(MAX_WIN)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void clear_window();
    win_wr_ptr = 0;
    win_held   = 0;
    win_seen   = 0;
  endfunction

  // Removes the oldest held sample; among equal values the first sorted entry goes.
  function automatic void evict_oldest();
    int slot;
    int k;
    int j;
    slot = (win_wr_ptr + MAX_WIN - win_held) % MAX_WIN;
    k = 0;
    while (k < win_held && win_sorted[k] != win_ring[slot]) k++;
    for (j = k; j < win_held - 1; j++) win_sorted[j] = win_sorted[j + 1];
    win_held--;
  endfunction

  function automatic median_t window_median_x2();
    int h;
    h = win_held;
    if (h % 2 == 1) begin
      return median_t'(2 * win_sorted[h / 2]);
    end else begin
      return median_t'(win_sorted[h / 2 - 1] + win_sorted[h / 2]);
    end
  endfunction

  function automatic void predict_medians(rmf_in_t beat);
    int       w;
    int       left;
    int       right;
    int       v;
    int       k;
    int       j;
    int       m;
    rmf_out_t res;
    w = (win_size == 0) ? 1 : int'(win_size);
    left = w / 2;
    right = w - left;
    v = int'(beat.sample);
    while (win_held >= w) evict_oldest();
    k = 0;
    while (k < win_held && win_sorted[k] < v) k++;
    for (j = win_held; j > k; j--) win_sorted[j] = win_sorted[j - 1];
    win_sorted[k] = v;
    win_ring[win_wr_ptr] = v;
    win_wr_ptr = (win_wr_ptr + 1) % MAX_WIN;
    win_held++;
    if (win_seen < right) win_seen++;
    if (win_seen > right) win_seen = right;
    if (!beat.last_sample) begin
      if (win_seen == right) begin
        res.median_x2 = window_median_x2();
        res.last_out  = 1'b0;
        median_q.push_back(res);
      end
    end else begin
      // End of set: the window shrinks from the left as the pending results drain.
      for (m = win_seen; m > 0; m--) begin
        while (win_held > left + m) evict_oldest();
        res.median_x2 = window_median_x2();
        res.last_out  = (m == 1);
        median_q.push_back(res);
      end
      clear_window();
    end
  endfunction

  // Entered at a falling edge; leaves valid high so that a gapless next beat follows.
  task automatic send_beat(rmf_in_t beat, logic fixed_exp, rmf_out_t fixed_res);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    predict_medians(beat);
    if (fixed_exp) median_q[median_q.size() - 1] = fixed_res;
    samples_sent++;
    if (beat.last_sample) sets_sent++;
    @(negedge clk_i);
  endtask

  // Lowers the input, waits for every pending value and lets the block settle.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_window(int w);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= WIN_BITS'(w);
    do @(posedge clk_i); while (!cfg_ready_o);
    win_size = WIN_BITS'(w);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_result(rmf_out_t got);
    rmf_out_t want;
    results_seen++;
    if (median_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("ERROR: unexpected beat median_x2=%0d last_out=%0b",
                 got.median_x2, got.last_out);
      end
    end else begin
      want = median_q.pop_front();
      if (got.median_x2 !== want.median_x2 || got.last_out !== want.last_out) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("ERROR: result %0d: median_x2 exp %0d got %0d, last_out exp %0b got %0b",
                   results_seen, want.median_x2, got.median_x2, want.last_out, got.last_out);
        end
      end
    end
  endtask

  // Output side: random stalls, and one long hold-off when asked for.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall = 150;
        hold_req = 1'b0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #2000000;
    $display("ERROR: timeout with %0d values outstanding", median_q.size());
    $display("running_median_filter_top_tb failed");
    $finish;
  end

  initial begin
    rmf_in_t  beat;
    rmf_out_t fixed_res;
    int       p;
    int       k;
    int       n;
    int       w;
    int       last_odds;
    bit       open_set;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = WIN_RESET;
    mismatch_count = 0;
    samples_sent   = 0;
    sets_sent      = 0;
    results_seen   = 0;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    hold_req       = 1'b0;
    clear_window();
    win_size = WIN_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Edge cases at the reset window size.
    foreach (STIM_ROWS[i]) begin
      beat.sample          = STIM_ROWS[i].smp;
      beat.last_sample     = STIM_ROWS[i].lst;
      fixed_res.median_x2  = STIM_ROWS[i].exp_med;
      fixed_res.last_out   = STIM_ROWS[i].exp_last;
      send_beat(beat, STIM_ROWS[i].fixed_exp, fixed_res);
    end

    // Random phases. Some leave their set open, so the next window size
    // is applied in the middle of a set.
    for (p = 0; p < 10; p++) begin
      case (p)
        0: w = 0;
        1: w = 1;
        2: w = 2;
        3: w = 63;
        4: w = 3;
        5: w = 4;
        default: w = $urandom_range(1, 20);
      endcase
      n = (w >= 32) ? 45 : ((p == 4) ? 24 : 6);
      open_set = (p == 3 || p == 6 || (p < 9 && $urandom_range(0, 3) == 0));
      last_odds = (w >= 20) ? 39 : 9;
      drain_and_settle();
      write_window(w);
      // In phase 4 the output stalls for a long while and the input keeps pushing; other phases may burst at random.
      tx_burst = (p == 4) || ($urandom_range(0, 3) == 0);
      if (p == 4) hold_req = 1'b1;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          beat.sample = SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
        end else begin
          beat.sample = SAMPLE_BITS'($urandom);
        end
        if (k == n - 1) begin
          beat.last_sample = !open_set;
        end else begin
          beat.last_sample = ($urandom_range(0, last_odds) == 0);
        end
        send_beat(beat, 1'b0, '0);
      end
    end

    drain_and_settle();
    $display("Sent %0d samples in %0d sets and checked %0d filtered values,",
             samples_sent, sets_sent, results_seen);
    $display("with window sizes from 0 to 63, short sets and resizes inside a set.");
    if (mismatch_count == 0 && median_q.size() == 0) begin
      $display("running_median_filter_top_tb passed");
    end else begin
      $display("ERROR: %0d mismatches, %0d values never arrived",
               mismatch_count, median_q.size());
      $display("running_median_filter_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rmf_pkg.sv
src/rmf_cell.sv
src/rmf_median.sv
src/running_median_filter_top.sv
tb/sv/running_median_filter_top_tb.sv
